### design/sra_pkg.sv
// Shared types and field widths for the skyline rectangle allocator.
`timescale 1ns / 1ps

package sra_pkg;

  // Widths of the request and result fields
  localparam int unsigned SizeW    = 10;
  localparam int unsigned PageIdxW = 3;
  localparam int unsigned PosW     = 9;

  // Sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FWD,
    S_BWD,
    S_PAGE,
    S_COMMIT,
    S_RESP
  } state_e;

  // Per-cycle controls decoded from the state
  typedef struct packed {
    logic issue;    // height read issued this cycle
    logic hm_we;    // height memory write
    logic resp_go;  // result moves into the output register
  } ctl_t;

endpackage

### design/skyline_rect_allocator_unit.sv
// Skyline rectangle allocator: height memory, scan sequencer and result register.
`timescale 1ns / 1ps

// Packs rectangles into MAX_PAGES square pages of PAGE_SIZE texels and keeps the
// used height of every column in one memory. An allocate request is checked for
// size, then pages are tried in order; in each page two passes over the columns
// find the leftmost window with the lowest maximum height (a forward pass that
// stores block prefix maxima in a scratch memory, a backward pass that merges
// them with block suffix maxima). A placement then raises the rect_width columns of
// the window before the result is handed out; a bad size goes straight to the
// response state. The height memory has a single read port, which delivers one
// column per cycle. A clear request, and the clearing pass after reset, sweep all
// MAX_PAGES*PAGE_SIZE heights at one entry per cycle; no request is taken during
// the pass after reset. One request is worked on at a time; in_stall_o is low only
// when the sequencer is idle, and the next request is taken while the previous
// result still waits in the output register.
module skyline_rect_allocator_unit #(
  parameter int unsigned PAGE_SIZE = 512,
  parameter int unsigned MAX_PAGES = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // request channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         action_i,
  input  logic [sra_pkg::SizeW-1:0]    rect_width_i,
  input  logic [sra_pkg::SizeW-1:0]    rect_height_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         ok_o,
  output logic [sra_pkg::PageIdxW-1:0] page_index_o,
  output logic [sra_pkg::PosW-1:0]     pos_x_o,
  output logic [sra_pkg::PosW-1:0]     pos_y_o
);

  import sra_pkg::*;

  localparam int unsigned Total = MAX_PAGES * PAGE_SIZE;
  localparam int unsigned AW    = $clog2(Total);
  localparam int unsigned CW    = $clog2(Total + 1);
  localparam int unsigned ColW  = $clog2(PAGE_SIZE);
  localparam int unsigned XW    = $clog2(PAGE_SIZE + 1);
  localparam int unsigned HW    = XW;
  localparam int unsigned PW    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;

  localparam logic [HW-1:0]   PageH    = HW'(PAGE_SIZE);
  localparam logic [HW:0]     PageHx   = (HW + 1)'(PAGE_SIZE);
  localparam logic [XW-1:0]   PageCnt  = XW'(PAGE_SIZE);
  localparam logic [XW:0]     LastColX = (XW + 1)'(PAGE_SIZE - 1);
  localparam logic [ColW-1:0] LastCol  = ColW'(PAGE_SIZE - 1);
  localparam logic [PW-1:0]   LastPage = PW'(MAX_PAGES - 1);
  localparam logic [AW-1:0]   PageStep = AW'(PAGE_SIZE);
  localparam logic [CW-1:0]   ClrLast  = CW'(Total - 1);

  // Sequencer and control registers
  state_e          state_q, state_d;
  logic [XW-1:0]   cnt_q;
  logic [CW-1:0]   clr_q;
  logic            rv_q;
  logic            clr_resp_q;
  logic            out_vld_q;

  // Datapath registers
  logic [ColW-1:0] rx_q;
  logic            rwin_q;
  logic [ColW-1:0] ph_q;
  logic [HW-1:0]   acc_q;
  logic [HW-1:0]   best_q;
  logic [ColW-1:0] bx_q;
  logic [PW-1:0]   page_q;
  logic [AW-1:0]   base_q;
  logic [XW-1:0]   w_q;
  logic [HW-1:0]   h_q;
  logic [AW-1:0]   ca_q;
  logic [HW-1:0]   wv_q;
  logic            res_ok_q;
  logic            res_fld_q;
  logic            ok_q;
  logic [PageIdxW-1:0] page_idx_q;
  logic [PosW-1:0] pos_x_q;
  logic [PosW-1:0] pos_y_q;

  // Memories
  logic [HW-1:0]   height_mem [Total];
  logic [HW-1:0]   scr_mem [PAGE_SIZE];
  logic [HW-1:0]   hm_rdata_q;
  logic [HW-1:0]   scr_rdata_q;

  // Combinational nets
  ctl_t            ctl;
  logic [AW-1:0]   hm_waddr;
  logic [HW-1:0]   hm_wdata;
  logic [AW-1:0]   rd_addr;
  logic [XW-1:0]   iss_x_full;
  logic [ColW-1:0] iss_x;
  logic [ColW-1:0] wm1;
  logic [XW:0]     win_sum;
  logic            win_ok;
  logic [ColW-1:0] scr_raddr;
  logic            in_acc;
  logic            bad_size;
  logic            acc_reset;
  logic [HW-1:0]   acc_n;
  logic [HW-1:0]   wmax;
  logic            take;
  logic [HW:0]     top_sum;
  logic            fit;
  logic            fwd_last;
  logic            bwd_last;
  logic [31:0]     page_ext;
  logic [31:0]     bx_ext;
  logic [31:0]     by_ext;

  // Request decode
  assign in_acc   = in_valid_i && (state_q == S_IDLE);
  assign bad_size = (rect_width_i == '0) || (rect_height_i == '0) ||
                    (int'(rect_width_i) > PAGE_SIZE) || (int'(rect_height_i) > PAGE_SIZE);

  // Column scan addressing: forward counts up, backward counts down
  assign wm1        = ColW'(w_q - XW'(1));
  assign iss_x_full = (state_q == S_FWD) ? (PageCnt - cnt_q) : (cnt_q - XW'(1));
  assign iss_x      = iss_x_full[ColW-1:0];
  assign rd_addr    = base_q + AW'(iss_x);
  assign win_sum    = (XW + 1)'(iss_x) + (XW + 1)'(wm1);
  assign win_ok     = (win_sum <= LastColX);
  assign scr_raddr  = win_ok ? win_sum[ColW-1:0] : '0;

  // Shared max unit: running block prefix (forward) or suffix (backward)
  always_comb begin
    if (state_q == S_FWD) begin
      acc_reset = (ph_q == '0);
    end else begin
      acc_reset = (ph_q == wm1) || (rx_q == LastCol);
    end
    acc_n = (acc_reset || (hm_rdata_q > acc_q)) ? hm_rdata_q : acc_q;
    wmax  = (scr_rdata_q > acc_n) ? scr_rdata_q : acc_n;
  end

  // Window pick: lowest top wins, ties go left since the scan runs right to left
  assign take     = (state_q == S_BWD) && rv_q && rwin_q &&
                    (wmax < PageH) && (wmax <= best_q);
  assign top_sum  = (HW + 1)'(best_q) + (HW + 1)'(h_q);
  assign fit      = (best_q < PageH) && (top_sum <= PageHx);
  assign fwd_last = rv_q && (rx_q == LastCol);
  assign bwd_last = rv_q && (rx_q == '0);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == ClrLast) begin
          state_d = clr_resp_q ? S_RESP : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          if (action_i) begin
            state_d = S_CLEAR;
          end else if (bad_size) begin
            state_d = S_RESP;
          end else begin
            state_d = S_FWD;
          end
        end
      end
      S_FWD: begin
        if (fwd_last) state_d = S_BWD;
      end
      S_BWD: begin
        if (bwd_last) state_d = S_PAGE;
      end
      S_PAGE: begin
        if (fit) begin
          state_d = S_COMMIT;
        end else if (page_q == LastPage) begin
          state_d = S_RESP;
        end else begin
          state_d = S_FWD;
        end
      end
      S_COMMIT: begin
        if (cnt_q == XW'(1)) state_d = S_RESP;
      end
      S_RESP: begin
        if (ctl.resp_go) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    ctl         = '0;
    hm_waddr    = ca_q;
    hm_wdata    = wv_q;
    in_stall_o  = (state_q != S_IDLE);
    ctl.issue   = ((state_q == S_FWD) || (state_q == S_BWD)) && (cnt_q != '0);
    ctl.resp_go = (state_q == S_RESP) && (!out_vld_q || !out_stall_i);
    case (state_q)
      S_CLEAR: begin
        ctl.hm_we = 1'b1;
        hm_waddr  = clr_q[AW-1:0];
        hm_wdata  = '0;
      end
      S_COMMIT: begin
        ctl.hm_we = 1'b1;
      end
      default: ctl.hm_we = 1'b0;
    endcase
  end

  // Height memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (ctl.hm_we) height_mem[hm_waddr] <= hm_wdata;
    hm_rdata_q <= height_mem[rd_addr];
  end

  // Scratch memory for block prefix maxima of the current page
  always_ff @(posedge clk_i) begin
    if ((state_q == S_FWD) && rv_q) scr_mem[rx_q] <= acc_n;
    scr_rdata_q <= scr_mem[scr_raddr];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      cnt_q      <= '0;
      clr_q      <= '0;
      rv_q       <= 1'b0;
      clr_resp_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rv_q    <= ctl.issue;
      if (ctl.resp_go) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: clr_q <= clr_q + CW'(1);
        S_IDLE: begin
          if (in_acc) begin
            clr_q      <= '0;
            clr_resp_q <= 1'b1;
            cnt_q      <= PageCnt;
          end
        end
        S_FWD: begin
          if (ctl.issue) begin
            cnt_q <= cnt_q - XW'(1);
          end else if (fwd_last) begin
            cnt_q <= PageCnt;
          end
        end
        S_BWD: begin
          if (ctl.issue) cnt_q <= cnt_q - XW'(1);
        end
        S_PAGE: begin
          cnt_q <= fit ? w_q : PageCnt;
        end
        S_COMMIT: cnt_q <= cnt_q - XW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    rx_q   <= iss_x;
    rwin_q <= win_ok;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          w_q       <= XW'(rect_width_i);
          h_q       <= HW'(rect_height_i);
          page_q    <= '0;
          base_q    <= '0;
          ph_q      <= '0;
          res_ok_q  <= action_i || !bad_size;
          res_fld_q <= 1'b0;
        end
      end
      S_FWD: begin
        if (rv_q) begin
          acc_q <= acc_n;
          if (rx_q != LastCol) begin
            ph_q <= (ph_q == wm1) ? '0 : ph_q + ColW'(1);
          end
          if (fwd_last) begin
            best_q <= PageH;
            bx_q   <= '0;
          end
        end
      end
      S_BWD: begin
        if (rv_q) begin
          acc_q <= acc_n;
          ph_q  <= (ph_q == '0) ? wm1 : ph_q - ColW'(1);
          if (take) begin
            best_q <= wmax;
            bx_q   <= rx_q;
          end
        end
      end
      S_PAGE: begin
        if (fit) begin
          ca_q      <= base_q + AW'(bx_q);
          wv_q      <= top_sum[HW-1:0];
          res_ok_q  <= 1'b1;
          res_fld_q <= 1'b1;
        end else if (page_q == LastPage) begin
          res_ok_q  <= 1'b0;
          res_fld_q <= 1'b0;
        end else begin
          page_q <= page_q + PW'(1);
          base_q <= base_q + PageStep;
          ph_q   <= '0;
        end
      end
      S_COMMIT: ca_q <= ca_q + AW'(1);
      default: ca_q <= ca_q;
    endcase
  end

  // Result register
  assign page_ext = 32'(page_q);
  assign bx_ext   = 32'(bx_q);
  assign by_ext   = 32'(best_q);

  always_ff @(posedge clk_i) begin
    if (ctl.resp_go) begin
      ok_q       <= res_ok_q;
      page_idx_q <= res_fld_q ? page_ext[PageIdxW-1:0] : '0;
      pos_x_q    <= res_fld_q ? bx_ext[PosW-1:0] : '0;
      pos_y_q    <= res_fld_q ? by_ext[PosW-1:0] : '0;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign ok_o         = ok_q;
  assign page_index_o = page_idx_q;
  assign pos_x_o      = pos_x_q;
  assign pos_y_o      = pos_y_q;

  // Heights change only during a clearing sweep or a commit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.hm_we |-> ((state_q == S_CLEAR) || (state_q == S_COMMIT)))
    else $error("height write outside clear or commit");

  // Committed height stays within the page and above the old top
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMMIT) |-> ((wv_q <= PageH) && (wv_q > best_q)))
    else $error("committed height out of range");

  // Page decision only after both scans have drained
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PAGE) |-> (!rv_q && (cnt_q == '0)))
    else $error("page decision with reads in flight");

  // A new result appears only out of the response state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == S_RESP))
    else $error("result without response state");

  // Best top never exceeds the page once a backward scan has started
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_BWD) || (state_q == S_PAGE)) |-> (best_q <= PageH))
    else $error("best top out of range");

endmodule

### test/tb_skyline_rect_allocator_unit.sv
// Self-checking testbench for the skyline rectangle allocator.
`timescale 1ns / 1ps

module tb_skyline_rect_allocator_unit;

  localparam int unsigned PAGE_SIZE   = 512;
  localparam int unsigned MAX_PAGES   = 8;
  localparam int unsigned CYCLE_LIMIT = 5_000_000;
  localparam int unsigned TAIL_CYCLES = 64;
  localparam int unsigned PHASES      = 4;
  localparam int unsigned PHASE_ITEMS = 35;

  // request kinds on action_i
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  typedef logic [sra_pkg::SizeW-1:0] size_t;

  typedef struct packed {
    logic                         ok;
    logic [sra_pkg::PageIdxW-1:0] page;
    logic [sra_pkg::PosW-1:0]     x;
    logic [sra_pkg::PosW-1:0]     y;
  } alloc_result_t;

  // Skyline of every page plus the results still owed by the block
  class alloc_scoreboard;
    size_t         skyline [MAX_PAGES][PAGE_SIZE];
    alloc_result_t placement_q[$];
    int            errors;
    int            placed;
    int            refused;
    int            clears;
    int            highest_page;

    function new();
      foreach (skyline[p, c]) skyline[p][c] = '0;
      errors       = 0;
      placed       = 0;
      refused      = 0;
      clears       = 0;
      highest_page = 0;
    endfunction

    // Work out the result of an accepted request and update the skyline
    function void note_request(logic act, size_t w, size_t h);
      alloc_result_t r;
      int            p;
      int            sx;
      int            j;
      int            best_x;
      int            best_y;
      int            top;
      bit            beaten;
      bit            fits;
      r    = '0;
      fits = 1'b0;
      if (act == ACT_CLEAR) begin
        foreach (skyline[pp, c]) skyline[pp][c] = '0;
        r.ok = 1'b1;
        clears++;
      end else if (w == 0 || h == 0 || w > PAGE_SIZE || h > PAGE_SIZE) begin
        refused++;
      end else begin
        for (p = 0; p < MAX_PAGES && !fits; p++) begin
          // leftmost window with the lowest top; stop a window once it loses
          best_y = PAGE_SIZE;
          best_x = 0;
          for (sx = 0; sx + w <= PAGE_SIZE; sx++) begin
            top    = 0;
            beaten = 1'b0;
            for (j = 0; j < w; j++) begin
              if (skyline[p][sx+j] >= best_y) begin
                beaten = 1'b1;
                break;
              end
              if (skyline[p][sx+j] > top) top = skyline[p][sx+j];
            end
            if (!beaten && top < best_y) begin
              best_y = top;
              best_x = sx;
            end
          end
          if (best_y + h <= PAGE_SIZE) begin
            for (j = 0; j < w; j++) skyline[p][best_x+j] = best_y + h;
            r.ok   = 1'b1;
            r.page = p;
            r.x    = best_x;
            r.y    = best_y;
            fits   = 1'b1;
            placed++;
            if (p > highest_page) highest_page = p;
          end
        end
        if (!fits) refused++;
      end
      placement_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    // Compare one accepted result with the oldest pending one
    function void check_result(alloc_result_t got);
      alloc_result_t want;
      if (placement_q.size() == 0) begin
        errors++;
        $display("%0t: result with no request pending: expected none, actual ok=%0d page=%0d x=%0d y=%0d",
                 $time, got.ok, got.page, got.x, got.y);
        return;
      end
      want = placement_q.pop_front();
      compare_field("ok", want.ok, got.ok);
      compare_field("page_index", want.page, got.page);
      compare_field("pos_x", want.x, got.x);
      compare_field("pos_y", want.y, got.y);
    endfunction
  endclass

  logic clk_i         = 1'b0;
  logic rst_ni        = 1'b0;
  logic in_valid_i    = 1'b0;
  logic action_i      = ACT_ALLOC;
  size_t rect_width_i  = '0;
  size_t rect_height_i = '0;
  logic out_stall_i   = 1'b0;

  logic                         in_stall_o;
  logic                         out_valid_o;
  logic                         ok_o;
  logic [sra_pkg::PageIdxW-1:0] page_index_o;
  logic [sra_pkg::PosW-1:0]     pos_x_o;
  logic [sra_pkg::PosW-1:0]     pos_y_o;

  alloc_scoreboard sb;
  int              send_idle_pct  = 0;
  int              recv_stall_pct = 0;
  int              requests_sent  = 0;
  int              cycle_count    = 0;
  int              send_pct_tab [PHASES] = '{0, 52, 0, 12};
  int              stall_pct_tab[PHASES] = '{0, 0, 52, 12};

  skyline_rect_allocator_unit #(
    .PAGE_SIZE(PAGE_SIZE),
    .MAX_PAGES(MAX_PAGES)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .rect_width_i (rect_width_i),
    .rect_height_i(rect_height_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .ok_o         (ok_o),
    .page_index_o (page_index_o),
    .pos_x_o      (pos_x_o),
    .pos_y_o      (pos_y_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result side: check accepted results, then pick the next stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result({ok_o, page_index_o, pos_x_o, pos_y_o});
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Guard against a hung block
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("** skyline_rect_allocator_unit: FAILED **");
    $finish;
  end

  // Send one request, with a random idle gap first; returns at the accepting edge
  task automatic send_request(input logic act, input size_t w, input size_t h);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    action_i      <= act;
    rect_width_i  <= w;
    rect_height_i <= h;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(act, w, h);
    requests_sent++;
  endtask

  // Hold off new requests until every pending result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.placement_q.size() != 0) @(posedge clk_i);
  endtask

  // Mostly small rectangles, some medium, a few up to the full page
  function automatic size_t pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 45) return $urandom_range(64, 1);
    if (r < 85) return $urandom_range(256, 65);
    return $urandom_range(PAGE_SIZE, 257);
  endfunction

  initial begin
    int    phase;
    int    n;
    int    kind;
    logic  act;
    size_t w;
    size_t h;
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // bad sizes at both ends
    send_request(ACT_ALLOC, 0, 5);
    send_request(ACT_ALLOC, 5, 0);
    send_request(ACT_ALLOC, 513, 10);
    send_request(ACT_ALLOC, 10, 513);
    send_request(ACT_ALLOC, 1023, 1023);
    // smallest and full-width rectangles, spill to the next page
    send_request(ACT_ALLOC, 1, 1);
    send_request(ACT_ALLOC, 512, 1);
    send_request(ACT_ALLOC, 512, 512);
    send_request(ACT_ALLOC, 512, 510);
    send_request(ACT_CLEAR, 1023, 1023);
    // stack up to the very top row
    send_request(ACT_ALLOC, 512, 511);
    send_request(ACT_ALLOC, 512, 1);
    send_request(ACT_CLEAR, 0, 0);
    // rightmost column is the lowest, then a tie goes left
    send_request(ACT_ALLOC, 511, 5);
    send_request(ACT_ALLOC, 1, 1);
    send_request(ACT_ALLOC, 2, 3);
    send_request(ACT_CLEAR, 1023, 0);
    // fill every page, then one more has no room
    for (n = 0; n < MAX_PAGES; n++) send_request(ACT_ALLOC, 512, 512);
    send_request(ACT_ALLOC, 1, 1);
    send_request(ACT_CLEAR, 0, 1023);
    drain();

    // random requests under each idling profile
    for (phase = 0; phase < PHASES; phase++) begin
      send_idle_pct  = send_pct_tab[phase];
      recv_stall_pct = stall_pct_tab[phase];
      for (n = 0; n < PHASE_ITEMS; n++) begin
        kind = $urandom_range(99);
        act  = ACT_ALLOC;
        w    = pick_size();
        h    = pick_size();
        if (kind < 3) begin
          act = ACT_CLEAR;
          w   = $urandom;
          h   = $urandom;
        end else if (kind < 11) begin
          w = $urandom;
          h = $urandom;
          case ($urandom_range(3))
            0:       w = 0;
            1:       h = 0;
            2:       w = $urandom_range(1023, PAGE_SIZE + 1);
            default: h = $urandom_range(1023, PAGE_SIZE + 1);
          endcase
        end
        send_request(act, w, h);
      end
      drain();
    end

    recv_stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d requests: %0d placed (pages up to %0d), %0d refused, %0d clears.",
             requests_sent, sb.placed, sb.highest_page, sb.refused, sb.clears);
    $display("Idling covered: none, sender only, receiver only, and both sides together.");
    if (sb.errors == 0 && sb.placement_q.size() == 0) begin
      $display("** skyline_rect_allocator_unit: PASSED **");
    end else begin
      $display("** skyline_rect_allocator_unit: FAILED **");
    end
    $finish;
  end

endmodule

### files.f
design/sra_pkg.sv
design/skyline_rect_allocator_unit.sv
test/tb_skyline_rect_allocator_unit.sv
